// File: rtl/core/gfyu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfyu_pkg
// Shared types and constants for the gyro frame yaw unwrap core.
// ----------------------------------------------------------------------------
package gfyu_pkg;

	localparam int TOTAL_WIDTH_DEFAULT = 40;
	localparam int TURN_WIDTH_DEFAULT  = 24;

	// Entries of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] HDR_BYTE   = 8'h55;
	localparam logic [7:0] TYPE_RATE  = 8'h52;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;

	typedef enum logic [2:0] {
		ST_ANGLE_OK     = 3'd0,
		ST_RATE_OK      = 3'd1,
		ST_BAD_HEADER   = 3'd2,
		ST_BAD_SUM      = 3'd3,
		ST_UNKNOWN_TYPE = 3'd4,
		ST_ZERO_SET     = 3'd5
	} status_t;

	// One classified transaction: the outcome plus the two 16-bit words
	// that a good frame may carry (bytes 4/5 and bytes 6/7).
	typedef struct packed {
		status_t     status;
		logic [15:0] word_45;
		logic [15:0] word_67;
	} frame_entry_t;

endpackage
`default_nettype wire

// File: rtl/core/gfyu_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfyu_if
// Valid/ready channels: the frame input and the result output.
// ----------------------------------------------------------------------------
interface gfyu_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] frame_header;
	logic [7:0] frame_type;
	logic [7:0] payload_2;
	logic [7:0] payload_3;
	logic [7:0] payload_4;
	logic [7:0] payload_5;
	logic [7:0] payload_6;
	logic [7:0] payload_7;
	logic [7:0] payload_8;
	logic [7:0] payload_9;
	logic [7:0] frame_sum;

	modport source (
		output valid, op, frame_header, frame_type, payload_2, payload_3, payload_4,
			payload_5, payload_6, payload_7, payload_8, payload_9, frame_sum,
		input  ready
	);
	modport sink (
		input  valid, op, frame_header, frame_type, payload_2, payload_3, payload_4,
			payload_5, payload_6, payload_7, payload_8, payload_9, frame_sum,
		output ready
	);
endinterface

interface gfyu_out_if #(
	parameter int TOTAL_WIDTH = gfyu_pkg::TOTAL_WIDTH_DEFAULT,
	parameter int TURN_WIDTH  = gfyu_pkg::TURN_WIDTH_DEFAULT
);
	logic                          valid;
	logic                          ready;
	logic [2:0]                    status;
	logic signed [15:0]            yaw_raw;
	logic signed [TOTAL_WIDTH-1:0] yaw_total;
	logic signed [TURN_WIDTH-1:0]  wrap_count;
	logic signed [TOTAL_WIDTH:0]   yaw_rel_total;
	logic signed [16:0]            yaw_rel;
	logic signed [15:0]            rate_raw;
	logic signed [15:0]            rate_filtered;

	modport source (
		output valid, status, yaw_raw, yaw_total, wrap_count, yaw_rel_total, yaw_rel,
			rate_raw, rate_filtered,
		input  ready
	);
	modport sink (
		input  valid, status, yaw_raw, yaw_total, wrap_count, yaw_rel_total, yaw_rel,
			rate_raw, rate_filtered,
		output ready
	);
endinterface
`default_nettype wire

// File: rtl/core/gfyu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfyu_front
// Accept transactions and classify them: type, header and checksum tests.
// ----------------------------------------------------------------------------
module gfyu_front (
	gfyu_in_if.sink               item,
	input  wire logic             q_full,
	output logic                  push,
	output gfyu_pkg::frame_entry_t entry
);

	logic [7:0] sum8;

	assign item.ready = !q_full;
	assign push       = item.valid && !q_full;

	// Low byte of the sum over bytes 0..9 (wraps in 8 bits)
	assign sum8 = item.frame_header + item.frame_type + item.payload_2 + item.payload_3
		+ item.payload_4 + item.payload_5 + item.payload_6 + item.payload_7
		+ item.payload_8 + item.payload_9;

	always_comb begin
		entry.word_45 = {item.payload_5, item.payload_4};
		entry.word_67 = {item.payload_7, item.payload_6};
		if (item.op) begin
			entry.status = gfyu_pkg::ST_ZERO_SET;
		end else begin
			unique case (item.frame_type)
				gfyu_pkg::TYPE_ANGLE, gfyu_pkg::TYPE_RATE: begin
					if (item.frame_header != gfyu_pkg::HDR_BYTE) begin
						entry.status = gfyu_pkg::ST_BAD_HEADER;
					end else if (sum8 != item.frame_sum) begin
						entry.status = gfyu_pkg::ST_BAD_SUM;
					end else if (item.frame_type == gfyu_pkg::TYPE_ANGLE) begin
						entry.status = gfyu_pkg::ST_ANGLE_OK;
					end else begin
						entry.status = gfyu_pkg::ST_RATE_OK;
					end
				end
				default: begin
					entry.status = gfyu_pkg::ST_UNKNOWN_TYPE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/gfyu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfyu_queue
// Short FIFO of classified transactions between front and back.
// ----------------------------------------------------------------------------
module gfyu_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire gfyu_pkg::frame_entry_t push_entry,
	input  wire logic                   pop,
	output logic                        full,
	output logic                        head_valid,
	output gfyu_pkg::frame_entry_t      head_entry
);

	localparam int DEPTH = gfyu_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gfyu_pkg::frame_entry_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slots_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/gfyu_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfyu_back
// Carry out classified transactions: unwrap, turn count, rate capture, zero,
// and the result register with the relative fold.
// ----------------------------------------------------------------------------
module gfyu_back #(
	parameter int TOTAL_WIDTH = gfyu_pkg::TOTAL_WIDTH_DEFAULT,
	parameter int TURN_WIDTH  = gfyu_pkg::TURN_WIDTH_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_valid,
	input  wire gfyu_pkg::frame_entry_t q_entry,
	output logic                        pop,
	gfyu_out_if.source                  result
);

	localparam logic signed [TOTAL_WIDTH-1:0] TOTAL_MAX = {1'b0, {(TOTAL_WIDTH-1){1'b1}}};
	localparam logic signed [TOTAL_WIDTH-1:0] TOTAL_MIN = {1'b1, {(TOTAL_WIDTH-1){1'b0}}};
	localparam logic signed [TURN_WIDTH-1:0]  TURN_MAX  = {1'b0, {(TURN_WIDTH-1){1'b1}}};
	localparam logic signed [TURN_WIDTH-1:0]  TURN_MIN  = {1'b1, {(TURN_WIDTH-1){1'b0}}};
	localparam logic signed [16:0]            HALF_TURN = 17'sd32768;
	localparam logic [15:0]                   HALF_CODE = 16'h8000;

	// State after the last committed transaction; doubles as stage-1 data
	logic                          s1_valid_q;
	gfyu_pkg::status_t             status_s1;
	logic signed [15:0]            prev_yaw_q;
	logic                          prev_valid_q;
	logic signed [TOTAL_WIDTH-1:0] total_q;
	logic signed [TURN_WIDTH-1:0]  turns_q;
	logic signed [TOTAL_WIDTH-1:0] zero_q;
	logic                          zero_valid_q;
	logic signed [15:0]            yaw_q;
	logic signed [15:0]            rate_raw_q;
	logic signed [15:0]            rate_filt_q;

	// Result register; the relative fields are also held state
	logic                          out_valid_q;
	gfyu_pkg::status_t             status_s2;
	logic signed [15:0]            yaw_s2;
	logic signed [TOTAL_WIDTH-1:0] total_s2;
	logic signed [TURN_WIDTH-1:0]  turns_s2;
	logic signed [TOTAL_WIDTH:0]   rel_total_s2;
	logic signed [16:0]            rel_yaw_s2;
	logic signed [15:0]            rate_raw_s2;
	logic signed [15:0]            rate_filt_s2;

	logic                          advance_s2;
	logic signed [15:0]            curr_yaw;
	logic signed [16:0]            delta;
	logic                          wrap_dn;
	logic                          wrap_up;
	logic signed [16:0]            delta_adj;
	logic signed [TOTAL_WIDTH:0]   total_sum;
	logic signed [TOTAL_WIDTH-1:0] total_sat;
	logic signed [TOTAL_WIDTH-1:0] angle_total;
	logic signed [TURN_WIDTH-1:0]  angle_turns;
	logic signed [TOTAL_WIDTH:0]   rel_total;
	logic [15:0]                   rel_low;
	logic signed [16:0]            rel_fold;

	assign advance_s2 = s1_valid_q && (!out_valid_q || result.ready);
	assign pop        = q_valid && (!s1_valid_q || advance_s2);

	// Unwrap step
	assign curr_yaw = $signed(q_entry.word_67);
	assign delta    = {curr_yaw[15], curr_yaw} - {prev_yaw_q[15], prev_yaw_q};
	assign wrap_dn  = (delta > HALF_TURN);
	assign wrap_up  = (delta < -HALF_TURN);
	// A full turn is 2^16; in 17 bits adding or subtracting it flips bit 16
	assign delta_adj = (wrap_dn || wrap_up) ? {~delta[16], delta[15:0]} : delta;
	assign total_sum = {total_q[TOTAL_WIDTH-1], total_q}
		+ {{(TOTAL_WIDTH-16){delta_adj[16]}}, delta_adj};

	always_comb begin
		if (total_sum[TOTAL_WIDTH] != total_sum[TOTAL_WIDTH-1]) begin
			total_sat = total_sum[TOTAL_WIDTH] ? TOTAL_MIN : TOTAL_MAX;
		end else begin
			total_sat = total_sum[TOTAL_WIDTH-1:0];
		end
	end

	always_comb begin
		if (!prev_valid_q) begin
			angle_total = {{(TOTAL_WIDTH-16){curr_yaw[15]}}, curr_yaw};
			angle_turns = '0;
		end else begin
			angle_total = total_sat;
			if (wrap_dn) begin
				angle_turns = (turns_q == TURN_MIN) ? TURN_MIN : turns_q - 1'b1;
			end else if (wrap_up) begin
				angle_turns = (turns_q == TURN_MAX) ? TURN_MAX : turns_q + 1'b1;
			end else begin
				angle_turns = turns_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			status_s1    <= gfyu_pkg::ST_ANGLE_OK;
			prev_yaw_q   <= '0;
			prev_valid_q <= 1'b0;
			total_q      <= '0;
			turns_q      <= '0;
			zero_q       <= '0;
			zero_valid_q <= 1'b0;
			yaw_q        <= '0;
			rate_raw_q   <= '0;
			rate_filt_q  <= '0;
		end else begin
			if (pop) begin
				s1_valid_q <= 1'b1;
			end else if (advance_s2) begin
				s1_valid_q <= 1'b0;
			end
			if (pop) begin
				status_s1 <= q_entry.status;
				unique case (q_entry.status)
					gfyu_pkg::ST_ZERO_SET: begin
						// No angle yet: re-arm the automatic zero instead
						zero_q       <= prev_valid_q ? total_q : '0;
						zero_valid_q <= prev_valid_q;
					end
					gfyu_pkg::ST_ANGLE_OK: begin
						prev_yaw_q   <= curr_yaw;
						prev_valid_q <= 1'b1;
						yaw_q        <= curr_yaw;
						total_q      <= angle_total;
						turns_q      <= angle_turns;
						if (!zero_valid_q) begin
							zero_q       <= angle_total;
							zero_valid_q <= 1'b1;
						end
					end
					gfyu_pkg::ST_RATE_OK: begin
						rate_raw_q  <= $signed(q_entry.word_45);
						rate_filt_q <= $signed(q_entry.word_67);
					end
					default: begin
						// Rejected frame: hold all state
					end
				endcase
			end
		end
	end

	// Relative total and fold into plus or minus a half turn
	assign rel_total = {total_q[TOTAL_WIDTH-1], total_q} - {zero_q[TOTAL_WIDTH-1], zero_q};
	assign rel_low   = rel_total[15:0];
	assign rel_fold  = ((rel_low > HALF_CODE) || ((rel_low == HALF_CODE) && rel_total[TOTAL_WIDTH]))
		? {1'b1, rel_low} : {1'b0, rel_low};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			status_s2    <= gfyu_pkg::ST_ANGLE_OK;
			yaw_s2       <= '0;
			total_s2     <= '0;
			turns_s2     <= '0;
			rel_total_s2 <= '0;
			rel_yaw_s2   <= '0;
			rate_raw_s2  <= '0;
			rate_filt_s2 <= '0;
		end else begin
			if (advance_s2) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance_s2) begin
				status_s2    <= status_s1;
				yaw_s2       <= yaw_q;
				total_s2     <= total_q;
				turns_s2     <= turns_q;
				rate_raw_s2  <= rate_raw_q;
				rate_filt_s2 <= rate_filt_q;
				unique case (status_s1)
					gfyu_pkg::ST_ANGLE_OK: begin
						rel_total_s2 <= rel_total;
						rel_yaw_s2   <= rel_fold;
					end
					gfyu_pkg::ST_ZERO_SET: begin
						rel_total_s2 <= '0;
						rel_yaw_s2   <= '0;
					end
					default: begin
						// Hold the last relative values
					end
				endcase
			end
		end
	end

	assign result.valid         = out_valid_q;
	assign result.status        = status_s2;
	assign result.yaw_raw       = yaw_s2;
	assign result.yaw_total     = total_s2;
	assign result.wrap_count    = turns_s2;
	assign result.yaw_rel_total = rel_total_s2;
	assign result.yaw_rel       = rel_yaw_s2;
	assign result.rate_raw      = rate_raw_s2;
	assign result.rate_filtered = rate_filt_s2;

endmodule
`default_nettype wire

// File: rtl/core/gyro_frame_yaw_unwrap_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gyro_frame_yaw_unwrap_core
// Gyro frame decoder with yaw unwrap, turn count and software zero.
// ----------------------------------------------------------------------------
// Each input transaction is either one 11-byte sensor frame (op = 0) or a
// set-zero command (op = 1), and each produces exactly one result
// transaction, in order. The block takes one transaction per clock while
// the queue has room; a result passes through the queue, the commit stage
// and the result register, and a stalled output backs up through the
// result register, the commit stage and a two-entry queue, four
// transactions in all, before the input ready drops. Angle frames
// (type 0x53) unwrap a signed 16-bit yaw (180/32768 degree per unit) into
// a saturating total and turn count; rate frames (type 0x52) latch a raw
// and a filtered z rate. Frames with an unknown type, a bad header or a
// bad checksum change nothing and report their status with the held
// values. The first angle frame sets the zero automatically; set-zero
// takes the current total as the new zero, or re-arms the automatic zero
// if no angle has arrived. yaw_rel is the relative total folded into
// plus or minus a half turn.
// ----------------------------------------------------------------------------
module gyro_frame_yaw_unwrap_core #(
	parameter int TOTAL_WIDTH = gfyu_pkg::TOTAL_WIDTH_DEFAULT,
	parameter int TURN_WIDTH  = gfyu_pkg::TURN_WIDTH_DEFAULT
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	gfyu_in_if.sink    item,
	gfyu_out_if.source result
);

	// Classified transactions waiting for the back end
	gfyu_pkg::frame_entry_t push_entry;
	gfyu_pkg::frame_entry_t head_entry;
	logic                   push;
	logic                   pop;
	logic                   q_full;
	logic                   head_valid;

	// Front: accept while the queue has room, classify in the same cycle
	gfyu_front u_front (
		.item   (item),
		.q_full (q_full),
		.push   (push),
		.entry  (push_entry)
	);

	// Queue: lets the front keep accepting while the back waits on output
	gfyu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	// Back: commit state in stage 1, fold and register the result in stage 2
	gfyu_back #(
		.TOTAL_WIDTH (TOTAL_WIDTH),
		.TURN_WIDTH  (TURN_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (head_valid),
		.q_entry (head_entry),
		.pop     (pop),
		.result  (result)
	);

endmodule
`default_nettype wire

// File: rtl/core/gfyu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfyu_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module gfyu_checker #(
	parameter int TOTAL_WIDTH = gfyu_pkg::TOTAL_WIDTH_DEFAULT
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          valid,
	input wire logic                          ready,
	input wire logic [2:0]                    status,
	input wire logic signed [TOTAL_WIDTH:0]   yaw_rel_total,
	input wire logic signed [16:0]            yaw_rel
);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(status) && $stable(yaw_rel_total)
			&& $stable(yaw_rel))
		else $error("result changed while stalled");

	// Set-zero clears both relative outputs
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (status == gfyu_pkg::ST_ZERO_SET) |-> (yaw_rel_total == '0) && (yaw_rel == '0))
		else $error("relative outputs not cleared on set-zero");

	// The fold keeps the low 16 bits of the relative total
	a_fold_bits: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> yaw_rel[15:0] == yaw_rel_total[15:0])
		else $error("fold does not match relative total");

	// The fold stays within plus or minus a half turn
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (yaw_rel <= 17'sd32768) && (yaw_rel >= -17'sd32768))
		else $error("fold out of range");

endmodule

bind gyro_frame_yaw_unwrap_core gfyu_checker #(
	.TOTAL_WIDTH (TOTAL_WIDTH)
) u_gfyu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.valid         (result.valid),
	.ready         (result.ready),
	.status        (result.status),
	.yaw_rel_total (result.yaw_rel_total),
	.yaw_rel       (result.yaw_rel)
);
`default_nettype wire
